[sv/frm_pkg.sv]
// ============================================================================
// frm_pkg : shared types and constants of the frame rate meter
// Field widths, fixed limits and the command/status structs that join the
// controller and the datapath.
// ============================================================================
package frm_pkg;

    localparam int unsigned TS_W     = 63;   // timestamp width, microseconds
    localparam int unsigned LIMIT_W  = 7;    // frame rate cap register width
    localparam int unsigned FRAME_W  = 13;   // frame_ms width
    localparam int unsigned SLEEP_W  = 10;   // sleep_ms width
    localparam int unsigned FPS_W    = 17;   // fps width
    localparam int unsigned OUT_W    = FRAME_W + SLEEP_W + FPS_W;
    localparam int unsigned IN_W     = 64;   // now_us padded to whole bytes

    localparam int unsigned US_PER_MS     = 1000;
    localparam int unsigned MS_PER_S      = 1000;
    localparam int unsigned FRAME_MAX_MS  = 5000;
    localparam int unsigned FRAME_DFLT_MS = 25;
    localparam int unsigned SLEEP_MAX_MS  = 1000;
    localparam int unsigned FPS_MAX       = 131071;

    // Interval numerator width: every magnitude below the "too long" limit fits.
    localparam int unsigned QDIV_W = 23;
    localparam logic [TS_W-1:0] MAG_BIG = TS_W'((FRAME_MAX_MS + 1) * US_PER_MS);

    // Divide by 1000 as a multiply by ceil(2^33 / 1000) and a shift;
    // exact for every 23-bit numerator.
    localparam int unsigned        RECIP_W  = 24;
    localparam int unsigned        RECIP_SH = 33;
    localparam logic [RECIP_W-1:0] MS_RECIP = RECIP_W'(8589935);

    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(50);

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic {
        DIV_PERIOD,
        DIV_FPS
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     mag;
        logic     ms_quot;
        logic     div_start;
        t_div_sel div_sel;
        logic     per_capture;
        logic     ms_capture;
        logic     sum_update;
        logic     fps_capture;
        logic     fps_zero;
        logic     out_load;
        logic     clr_write;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic div_done;
        logic sum_zero;
        logic out_free;
        logic clr_last;
    } t_stat;

endpackage

[sv/frm_div.sv]
// ============================================================================
// frm_div : serial restoring divider
// Produces one quotient bit per cycle; the quotient is valid while done is
// high and holds until the next start.
// ============================================================================
module frm_div #(
    parameter int NW = 23,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Shift the numerator out on top, quotient bits in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[sv/frm_ctrl.sv]
// ============================================================================
// frm_ctrl : sequencing state machine of the frame rate meter
// Runs the clearing pass after reset, then steps each request through the
// difference, any division, a frame's window update and the result hand-off.
// ============================================================================
module frm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  frm_pkg::t_stat i_stat,
    output frm_pkg::t_cmd  o_cmd
);

    import frm_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MAG     = 4'd2;
    localparam logic [3:0] S_MS_QUOT = 4'd3;
    localparam logic [3:0] S_PER_RUN = 4'd4;
    localparam logic [3:0] S_MS_CAP  = 4'd5;
    localparam logic [3:0] S_SUM     = 4'd6;
    localparam logic [3:0] S_FPS_GO  = 4'd7;
    localparam logic [3:0] S_FPS_RUN = 4'd8;
    localparam logic [3:0] S_RESULT  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state       = r_state;
        w_cmd         = '0;
        w_cmd.div_sel = DIV_PERIOD;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_MAG;
                end
            end
            S_MAG: begin
                w_cmd.mag = 1'b1;
                // the period does not depend on the magnitude: start it now
                if (i_stat.kind == KIND_QUERY) begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DIV_PERIOD;
                    n_state         = S_PER_RUN;
                end else begin
                    n_state = S_MS_QUOT;
                end
            end
            S_MS_QUOT: begin
                w_cmd.ms_quot = 1'b1;
                n_state       = S_MS_CAP;
            end
            S_PER_RUN: begin
                if (i_stat.div_done) begin
                    w_cmd.per_capture = 1'b1;
                    n_state           = S_MS_QUOT;
                end
            end
            S_MS_CAP: begin
                w_cmd.ms_capture = 1'b1;
                n_state = (i_stat.kind == KIND_QUERY) ? S_RESULT : S_SUM;
            end
            S_SUM: begin
                w_cmd.sum_update = 1'b1;
                n_state          = S_FPS_GO;
            end
            S_FPS_GO: begin
                if (i_stat.sum_zero) begin
                    w_cmd.fps_zero = 1'b1;
                    n_state        = S_RESULT;
                end else begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DIV_FPS;
                    n_state         = S_FPS_RUN;
                end
            end
            S_FPS_RUN: begin
                if (i_stat.div_done) begin
                    w_cmd.fps_capture = 1'b1;
                    n_state           = S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign o_cmd    = w_cmd;

endmodule

[sv/frm_dpath.sv]
// ============================================================================
// frm_dpath : datapath of the frame rate meter
// Start time, interval ring, running sum, shared divider, result register
// and the rate cap register.
// ============================================================================
module frm_dpath #(
    parameter int WINDOW = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  frm_pkg::t_cmd               i_cmd,
    output frm_pkg::t_stat              o_stat,
    input  logic [frm_pkg::IN_W-1:0]    s_tdata,
    input  logic                        s_tuser,
    input  logic                        i_cfg_we,
    input  logic [frm_pkg::LIMIT_W-1:0] i_cfg_wdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [frm_pkg::OUT_W-1:0]   m_tdata
);

    import frm_pkg::*;

    localparam int PW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = $clog2(WINDOW * FRAME_MAX_MS + 1);
    localparam int FPS_NUM = WINDOW * MS_PER_S;
    localparam int FNUM_W  = $clog2(FPS_NUM + 1);
    localparam int DIV_NW  = (FNUM_W > FPS_W) ? FNUM_W : FPS_W;
    localparam int DIV_DW  = (SUM_W > SLEEP_W) ? SUM_W : SLEEP_W;
    localparam int SW      = SLEEP_W + 4;
    localparam int PROD_W  = QDIV_W + RECIP_W;

    logic [LIMIT_W-1:0] r_limit;
    logic [TS_W-1:0]    r_cur;
    logic               r_kind;
    logic [TS_W:0]      r_diff;
    logic [TS_W-1:0]    r_mag;
    logic               r_neg;
    logic [FRAME_W-1:0] r_q13;
    logic [SLEEP_W-1:0] r_period;
    logic [FRAME_W-1:0] r_ms;
    logic [SLEEP_W-1:0] r_sleep;
    logic [FPS_W-1:0]   r_fps;
    logic [SUM_W-1:0]   r_sum;
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      r_clr_addr;
    logic [FRAME_W-1:0] r_old;
    logic [FRAME_W-1:0] r_ring [WINDOW];
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic [TS_W-1:0]    w_now;
    logic               w_big;
    logic [PROD_W-1:0]  w_prod;
    logic [SW-1:0]      w_p;
    logic [SW-1:0]      w_q;
    logic               w_ovf;
    logic [SW-1:0]      w_sleep;
    logic [FRAME_W-1:0] w_ms;
    logic               w_we;
    logic [PW-1:0]      w_waddr;
    logic [FRAME_W-1:0] w_wdata;
    logic [PW-1:0]      w_pos_next;
    logic [FRAME_W-1:0] w_frame_out;
    logic [SLEEP_W-1:0] w_sleep_out;
    logic [DIV_NW-1:0]  w_num;
    logic [DIV_DW-1:0]  w_den;
    logic               w_div_done;
    logic [DIV_NW-1:0]  w_quot;

    assign w_now = s_tdata[TS_W-1:0];
    assign w_big = (r_mag >= MAG_BIG);

    // Whole milliseconds of the magnitude by reciprocal multiplication.
    assign w_prod = PROD_W'(r_mag[QDIV_W-1:0]) * PROD_W'(MS_RECIP);

    // Operand select for the shared divider.
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_PERIOD: begin
                w_num = DIV_NW'(MS_PER_S);
                w_den = DIV_DW'(r_limit);
            end
            DIV_FPS: begin
                w_num = DIV_NW'(FPS_NUM);
                w_den = DIV_DW'(r_sum);
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    frm_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Interval: a long or backward gap falls back to the default,
    // a backward gap under one millisecond truncates to zero.
    always_comb begin
        if (!r_neg) begin
            w_ms = w_big ? FRAME_W'(FRAME_DFLT_MS) : r_q13;
        end else if (r_mag < TS_W'(US_PER_MS)) begin
            w_ms = '0;
        end else begin
            w_ms = FRAME_W'(FRAME_DFLT_MS);
        end
    end

    // Time left in the period; drop to zero when out of range.
    assign w_p = SW'(r_period);
    assign w_q = SW'(r_q13);
    always_comb begin
        if (!r_neg) begin
            w_ovf   = w_big || (w_q > w_p);
            w_sleep = w_p - w_q;
        end else begin
            w_ovf   = w_big || (w_q > (SW'(SLEEP_MAX_MS) - w_p));
            w_sleep = w_p + w_q;
        end
    end

    assign w_pos_next = (r_pos == PW'(WINDOW - 1)) ? '0 : r_pos + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RST;
            r_cur       <= '0;
            r_kind      <= KIND_FRAME;
            r_sum       <= '0;
            r_pos       <= '0;
            r_clr_addr  <= '0;
            r_fps       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (i_cmd.capture) begin
                r_kind <= s_tuser;
                if (s_tuser == KIND_FRAME) r_cur <= w_now;
            end
            if (i_cmd.clr_write) r_clr_addr <= r_clr_addr + PW'(1);
            if (i_cmd.sum_update) begin
                r_sum <= r_sum - SUM_W'(r_old) + SUM_W'(r_ms);
                r_pos <= w_pos_next;
            end
            if (i_cmd.fps_zero) begin
                r_fps <= '0;
            end else if (i_cmd.fps_capture) begin
                r_fps <= (w_quot > DIV_NW'(FPS_MAX)) ? FPS_W'(FPS_MAX)
                                                     : w_quot[FPS_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_frame_out = (r_kind == KIND_FRAME) ? r_ms : '0;
    assign w_sleep_out = (r_kind == KIND_QUERY) ? r_sleep : '0;

    always_ff @(posedge i_clk) begin
        // the difference uses the start time from before this request
        if (i_cmd.capture) r_diff <= {1'b0, w_now} - {1'b0, r_cur};
        if (i_cmd.mag) begin
            r_neg <= r_diff[TS_W];
            r_mag <= r_diff[TS_W] ? (TS_W'(0) - r_diff[TS_W-1:0]) : r_diff[TS_W-1:0];
        end
        if (i_cmd.ms_quot) r_q13 <= w_prod[RECIP_SH +: FRAME_W];
        if (i_cmd.per_capture) begin
            r_period <= (r_limit == '0) ? '0 : w_quot[SLEEP_W-1:0];
        end
        if (i_cmd.ms_capture) begin
            r_ms    <= w_ms;
            r_sleep <= w_ovf ? '0 : w_sleep[SLEEP_W-1:0];
        end
        if (i_cmd.out_load) r_out_data <= {r_fps, w_sleep_out, w_frame_out};
    end

    // Interval ring: one write port, one registered read port.
    assign w_we    = i_cmd.clr_write || i_cmd.sum_update;
    assign w_waddr = i_cmd.clr_write ? r_clr_addr : r_pos;
    assign w_wdata = i_cmd.clr_write ? '0 : r_ms;

    always_ff @(posedge i_clk) begin
        if (w_we) r_ring[w_waddr] <= w_wdata;
        if (i_cmd.capture) r_old <= r_ring[r_pos];
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.div_done = w_div_done;
    assign o_stat.sum_zero = (r_sum == '0);
    assign o_stat.out_free = !r_out_valid || m_tready;
    assign o_stat.clr_last = (r_clr_addr == PW'(WINDOW - 1));

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || m_tready))
        else $error("result loaded over an untaken result");

    a_sum_covers_old: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum_update |-> (r_sum >= SUM_W'(r_old)))
        else $error("window sum below the entry being replaced");

    a_fps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fps_capture |-> (r_sum != '0))
        else $error("fps division run on an empty window");

endmodule

[sv/frame_rate_meter.sv]
// ============================================================================
// frame_rate_meter : moving-window frame rate counter
// Frame start events fill a window of intervals; sleep queries report the
// time left in the frame period. Every result carries the current fps.
// ============================================================================
// Division: a sleep query and a frame start each wait on a 17-step serial
//   division; a frame start skips it when the window sum is zero.
// Throughput: one request at a time; the next is taken the cycle after the
//   result enters the output register, which holds it until taken.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every
//   entry of the interval ring with s_tready low. The rate cap resets to 50.
module frame_rate_meter #(
    parameter int WINDOW = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [frm_pkg::IN_W-1:0]    s_tdata,   // [62:0] now_us, [63] zero
    input  logic                        s_tuser,   // [0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [frm_pkg::OUT_W-1:0]   m_tdata,   // [12:0] frame_ms, [22:13] sleep_ms,
                                                   // [39:23] fps
    input  logic                        i_cfg_we,
    input  logic [frm_pkg::LIMIT_W-1:0] i_cfg_wdata
);

    import frm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    frm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    frm_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

[sim/frame_rate_meter_tb.sv]
// ----------------------------------------------------------------------------
// frame_rate_meter_tb : self-checking bench for the frame rate meter
// Drives frame start events and sleep queries over the input stream, predicts
// each result with a local model of the interval window or a typed directed
// row, and compares it field by field. A directed table covers the interval
// and sleep limits, then random phases run under several rate cap settings.
// ----------------------------------------------------------------------------
module frame_rate_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frm_pkg::*;

    localparam int          WIN          = 100;
    localparam int          PHASES       = 10;
    localparam int          PHASE_ITEMS  = 183;
    localparam int          DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    // Same layout as m_tdata: frame_ms in the low bits
    typedef struct packed {
        logic [FPS_W-1:0]   fps;
        logic [SLEEP_W-1:0] sleep_ms;
        logic [FRAME_W-1:0] frame_ms;
    } t_meter_result;

    typedef enum logic { ROW_REQUEST, ROW_SETUP } t_row_op;

    typedef struct {
        t_row_op             op;
        logic                kind;
        logic [TS_W-1:0]     now_us;
        logic [LIMIT_W-1:0]  limit;
        bit                  typed;
        t_meter_result       want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 i_cfg_we;
    logic [LIMIT_W-1:0]   i_cfg_wdata;

    frame_rate_meter #(.WINDOW(WIN)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Local copy of the meter state
    logic [TS_W-1:0]    start_now_us;
    logic [TS_W-1:0]    start_prev_us;
    int unsigned        interval_win [WIN];
    int unsigned        win_pos;
    int unsigned        win_sum;
    logic [LIMIT_W-1:0] rate_cap_q;

    t_meter_result pending_results [$];
    t_stim_row     dir_rows [$];

    int          n_fail;
    int          n_checked;
    int          n_frames;
    int          n_queries;
    int          n_setups;
    int unsigned cycle_count = 0;
    bit          tx_quiet;
    bit          rx_quiet;
    int          rx_hold;

    function automatic void reset_meter_model();
        start_now_us  = '0;
        start_prev_us = '0;
        foreach (interval_win[i]) interval_win[i] = 0;
        win_pos     = 0;
        win_sum     = 0;
        rate_cap_q  = LIMIT_RST;
    endfunction

    function automatic t_meter_result step_meter(input logic kind, input logic [TS_W-1:0] now_us);
        t_meter_result    res;
        longint unsigned  ms;
        int unsigned      frame;
        int unsigned      period;
        int unsigned      rate;
        res = '0;
        if (kind == KIND_FRAME) begin
            start_prev_us = start_now_us;
            start_now_us  = now_us;
            if (start_now_us >= start_prev_us) begin
                ms    = (start_now_us - start_prev_us) / US_PER_MS;
                frame = (ms > FRAME_MAX_MS) ? FRAME_DFLT_MS : int'(ms);
            end else begin
                // a step back shorter than one millisecond truncates to zero
                ms    = (start_prev_us - start_now_us) / US_PER_MS;
                frame = (ms == 0) ? 0 : FRAME_DFLT_MS;
            end
            win_sum = win_sum - interval_win[win_pos] + frame;
            interval_win[win_pos] = frame;
            win_pos = (win_pos == WIN - 1) ? 0 : win_pos + 1;
            res.frame_ms = FRAME_W'(frame);
        end else begin
            period = (rate_cap_q == 0) ? 0 : MS_PER_S / rate_cap_q;
            if (now_us >= start_now_us) begin
                ms = (now_us - start_now_us) / US_PER_MS;
                res.sleep_ms = (ms > period) ? '0 : SLEEP_W'(period - ms);
            end else begin
                ms = (start_now_us - now_us) / US_PER_MS;
                res.sleep_ms = (ms > SLEEP_MAX_MS - period) ? '0 : SLEEP_W'(period + ms);
            end
        end
        if (win_sum == 0) begin
            rate = 0;
        end else begin
            rate = (WIN * 1000) / win_sum;
            if (rate > FPS_MAX) rate = FPS_MAX;
        end
        res.fps = FPS_W'(rate);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic void add_request(input logic kind, input logic [TS_W-1:0] now_us);
        t_stim_row row;
        row = '{ROW_REQUEST, kind, now_us, '0, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic kind, input logic [TS_W-1:0] now_us,
                                      input int unsigned frame, input int unsigned sleep,
                                      input int unsigned rate);
        t_stim_row row;
        row = '{ROW_REQUEST, kind, now_us, '0, 1'b1, '0};
        row.want.frame_ms = FRAME_W'(frame);
        row.want.sleep_ms = SLEEP_W'(sleep);
        row.want.fps      = FPS_W'(rate);
        dir_rows.push_back(row);
    endfunction

    function automatic void add_setup(input logic [LIMIT_W-1:0] limit);
        t_stim_row row;
        row = '{ROW_SETUP, KIND_FRAME, '0, limit, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls unless quiet
    initial begin
        m_tready = 1'b0;
        rx_hold  = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold  = rx_hold - 1;
            end else begin
                m_tready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 3) == 0) rx_hold = idle_len();
            end
        end
    end

    task automatic report_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_meter_result got;
        t_meter_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_meter_result'(m_tdata);
            if (pending_results.size() == 0) begin
                $error("result with no request pending: %h", m_tdata);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                report_field("frame_ms", want.frame_ms, got.frame_ms);
                report_field("sleep_ms", want.sleep_ms, got.sleep_ms);
                report_field("fps", want.fps, got.fps);
                n_checked++;
            end
        end
    end

    // Hold the request side low until every result is back
    task automatic hold_until_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        hold_until_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        rate_cap_q   = limit;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_setups++;
    endtask

    task automatic send_request(input logic kind, input logic [TS_W-1:0] now_us,
                                input bit typed, input t_meter_result want);
        int            gap;
        t_meter_result res;
        gap = tx_quiet ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, now_us};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
        res = step_meter(kind, now_us);
        pending_results.push_back(typed ? want : res);
        if (kind == KIND_FRAME) n_frames++;
        else n_queries++;
    endtask

    task automatic random_request();
        int               r;
        logic             kind;
        logic [TS_W-1:0]  now_us;
        logic [63:0]      noise;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            kind = KIND_FRAME;
            r = $urandom_range(0, 99);
            if (r < 80)      now_us = start_now_us + $urandom_range(0, 60_000);
            else if (r < 88) now_us = start_now_us + $urandom_range(0, 2_999);
            else if (r < 93) now_us = start_now_us + $urandom_range(4_990_000, 5_010_000);
            else             now_us = start_now_us - $urandom_range(0, 3_000);
        end else if (r < 85) begin
            kind = KIND_QUERY;
            if ($urandom_range(0, 4) != 0) now_us = start_now_us + $urandom_range(0, 1_200_000);
            else                           now_us = start_now_us - $urandom_range(0, 1_100_000);
        end else begin
            noise  = {$urandom, $urandom};
            kind   = noise[63];
            now_us = noise[TS_W-1:0];
        end
        send_request(kind, now_us, 1'b0, '0);
    endtask

    initial begin
        logic [LIMIT_W-1:0] limit;
        n_fail      = 0;
        n_checked   = 0;
        n_frames    = 0;
        n_queries   = 0;
        n_setups    = 0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        reset_meter_model();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the rate cap starts at 50, so the frame period is 20 ms
        add_typed(KIND_QUERY, 63'd0, 0, 20, 0);
        add_typed(KIND_FRAME, 63'd0, 0, 0, 0);
        add_typed(KIND_FRAME, 63'd1_000, 1, 0, 100_000);
        add_typed(KIND_FRAME, 63'd5_001_000, 5000, 0, 19);
        add_typed(KIND_FRAME, 63'd10_002_000, 25, 0, 19);     // interval too long
        add_typed(KIND_FRAME, 63'd10_001_500, 0, 0, 19);      // backward under 1 ms
        add_typed(KIND_FRAME, 63'd9_999_500, 25, 0, 19);      // backward 2 ms
        add_request(KIND_FRAME, {TS_W{1'b1}});
        add_request(KIND_QUERY, {TS_W{1'b1}});
        add_request(KIND_QUERY, 63'd0);
        add_request(KIND_FRAME, 63'd100_000_000);
        add_request(KIND_QUERY, 63'd100_020_999);
        add_request(KIND_QUERY, 63'd100_019_999);
        add_request(KIND_QUERY, 63'd99_020_000);
        add_request(KIND_QUERY, 63'd99_019_000);
        add_setup(7'd0);
        add_request(KIND_QUERY, 63'd100_000_000);
        add_request(KIND_QUERY, 63'd99_000_001);
        add_request(KIND_QUERY, 63'd99_000_000);
        add_request(KIND_QUERY, 63'd98_999_000);
        add_setup(7'd1);
        add_request(KIND_QUERY, 63'd100_000_000);
        add_request(KIND_QUERY, 63'd101_000_999);
        add_setup(7'd120);
        add_request(KIND_QUERY, 63'd100_003_000);
        add_setup(7'd127);
        add_request(KIND_QUERY, 63'd100_000_000);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_SETUP) write_limit(dir_rows[i].limit);
            else send_request(dir_rows[i].kind, dir_rows[i].now_us,
                              dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: limit = 7'd0;
                1: limit = 7'd1;
                2: limit = 7'd120;
                3: limit = 7'd127;
                4: limit = LIMIT_RST;
                default: limit = LIMIT_W'($urandom_range(0, 127));
            endcase
            write_limit(limit);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 59) == 0) hold_until_drained();
                random_request();
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d frame starts, %0d sleep queries, %0d limit writes",
                 n_checked, n_frames, n_queries, n_setups);
        $display("Window wrapped %0d times; the rate cap ran through 0, 1, 120, 127 and others",
                 n_frames / WIN);
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
